[sv/cts_pkg.sv]
// ----------------------------------------------------------------------------
// cts_pkg
// Shared types and constants of the configuration token syntax checker.
// ----------------------------------------------------------------------------
`default_nettype none

package cts_pkg;

  localparam int LINE_BITS = 16;
  localparam int KIND_BITS = 4;
  localparam int VERDICT_BITS = 2;
  localparam int CODE_BITS = 3;

  localparam int QDEPTH = 2;
  localparam int QPTR_BITS = $clog2(QDEPTH);
  localparam int QCNT_BITS = $clog2(QDEPTH + 1);

  typedef enum logic [KIND_BITS-1:0] {
    TK_KEY     = 4'd0,
    TK_DOT     = 4'd1,
    TK_ASSIGN  = 4'd2,
    TK_VALUE   = 4'd3,
    TK_QUOTE   = 4'd4,
    TK_COMMA   = 4'd5,
    TK_OPEN    = 4'd6,
    TK_CLOSE   = 4'd7,
    TK_NEWLINE = 4'd8,
    TK_COMMENT = 4'd9,
    TK_EOF     = 4'd10,
    TK_OTHER   = 4'd11
  } tok_class_t;

  typedef enum logic [VERDICT_BITS-1:0] {
    V_PENDING = 2'd0,
    V_ACCEPT  = 2'd1,
    V_REJECT  = 2'd2
  } verdict_t;

  typedef enum logic [CODE_BITS-1:0] {
    E_NONE   = 3'd0,
    E_HEADER = 3'd1,
    E_KEY    = 3'd2,
    E_VALUE  = 3'd3,
    E_START  = 3'd4,
    E_TRAIL  = 3'd5
  } err_t;

  typedef enum logic [11:0] {
    PH_LINE          = 12'b0000_0000_0001,
    PH_HDR_OPEN      = 12'b0000_0000_0010,
    PH_HDR_KEY       = 12'b0000_0000_0100,
    PH_HDR_AFTER_KEY = 12'b0000_0000_1000,
    PH_HDR_CLOSE2    = 12'b0000_0001_0000,
    PH_KV_KEY        = 12'b0000_0010_0000,
    PH_KV_AFTER_KEY  = 12'b0000_0100_0000,
    PH_KV_VALUE      = 12'b0000_1000_0000,
    PH_ARR_ITEM      = 12'b0001_0000_0000,
    PH_ARR_AFTER     = 12'b0010_0000_0000,
    PH_TRAIL         = 12'b0100_0000_0000,
    PH_TRAIL_CMT     = 12'b1000_0000_0000
  } phase_t;

  typedef struct packed {
    tok_class_t           cls;
    logic [LINE_BITS-1:0] line;
    logic                 first;
  } tok_t;

endpackage

`default_nettype wire

[sv/cts_if.sv]
// ----------------------------------------------------------------------------
// cts_if
// Valid/ready channels of the checker: token items in, verdict items out.
// ----------------------------------------------------------------------------
`default_nettype none

interface cts_in_if;
  logic                           valid;
  logic                           ready;
  logic [cts_pkg::KIND_BITS-1:0]  token_kind;
  logic [cts_pkg::LINE_BITS-1:0]  line_number;
  logic                           first_of_document;

  modport source (output valid, token_kind, line_number, first_of_document,
                  input ready);
  modport sink (input valid, token_kind, line_number, first_of_document,
                output ready);
endinterface

interface cts_out_if;
  logic                             valid;
  logic                             ready;
  logic [cts_pkg::VERDICT_BITS-1:0] verdict;
  logic [cts_pkg::CODE_BITS-1:0]    error_code;
  logic [cts_pkg::LINE_BITS-1:0]    error_line;

  modport source (output valid, verdict, error_code, error_line, input ready);
  modport sink (input valid, verdict, error_code, error_line, output ready);
endinterface

`default_nettype wire

[sv/config_token_syntax_checker.sv]
// ----------------------------------------------------------------------------
// config_token_syntax_checker
// Streaming line-grammar checker for a token stream of a TOML-like file.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan carries one lexer token per item (kind, line, first-of-document).
//   out_chan returns one verdict item per token: pending, accepted or
//   rejected with an error code and the line of the offending token.
//   A token with first_of_document set restarts the checker at line start.
//   Once a verdict is reached it is repeated until the next document starts.
//   Path: a token accepted on in_chan is first written into the two-entry
//   token queue and then registered by the grammar stage for out_chan.
//   Throughput: one token per cycle; the grammar stage takes one queued
//   token per cycle whenever its result register is free or being drained.
//   When out_chan stalls, the result is held, up to two tokens wait in the
//   queue, and in_chan.ready drops once the queue is full.
//   Reset (rst_n low, synchronous) empties the queue, drops any pending
//   result and returns the grammar to line start with a pending verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module config_token_syntax_checker (
  input  wire logic  clk,
  input  wire logic  rst_n,
  cts_in_if.sink     in_chan,
  cts_out_if.source  out_chan
);

  logic          push, pop, q_full, q_valid;
  cts_pkg::tok_t push_tok, head;

  cts_front u_front (
    .in_chan  (in_chan),
    .q_full   (q_full),
    .push     (push),
    .push_tok (push_tok)
  );

  cts_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_tok (push_tok),
    .pop      (pop),
    .full     (q_full),
    .q_valid  (q_valid),
    .head     (head)
  );

  cts_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .head     (head),
    .pop      (pop),
    .out_chan (out_chan)
  );

endmodule

`default_nettype wire

[sv/cts_front.sv]
// ----------------------------------------------------------------------------
// cts_front
// Accepts token items and classifies the token kind before queueing.
// ----------------------------------------------------------------------------
`default_nettype none

module cts_front (
  cts_in_if.sink        in_chan,
  input  wire logic     q_full,
  output logic          push,
  output cts_pkg::tok_t push_tok
);

  always_comb begin
    push_tok.line  = in_chan.line_number;
    push_tok.first = in_chan.first_of_document;
    // fold every unused kind code onto the catch-all class
    if (in_chan.token_kind <= cts_pkg::KIND_BITS'(cts_pkg::TK_EOF)) begin
      push_tok.cls = cts_pkg::tok_class_t'(in_chan.token_kind);
    end else begin
      push_tok.cls = cts_pkg::TK_OTHER;
    end
  end

  assign in_chan.ready = !q_full;
  assign push          = in_chan.valid && !q_full;

endmodule

`default_nettype wire

[sv/cts_queue.sv]
// ----------------------------------------------------------------------------
// cts_queue
// Short queue of classified tokens between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module cts_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire cts_pkg::tok_t push_tok,
  input  wire logic          pop,
  output logic               full,
  output logic               q_valid,
  output cts_pkg::tok_t      head
);

  cts_pkg::tok_t                   mem_r [cts_pkg::QDEPTH];
  logic [cts_pkg::QPTR_BITS-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [cts_pkg::QPTR_BITS-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [cts_pkg::QCNT_BITS-1:0]   count_r, count_nxt;

  function automatic logic [cts_pkg::QPTR_BITS-1:0] bump(
    input logic [cts_pkg::QPTR_BITS-1:0] p
  );
    if (p == cts_pkg::QPTR_BITS'(cts_pkg::QDEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  assign full    = (count_r == cts_pkg::QCNT_BITS'(cts_pkg::QDEPTH));
  assign q_valid = (count_r != '0);
  assign head    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? bump(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? bump(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

[sv/cts_back.sv]
// ----------------------------------------------------------------------------
// cts_back
// Line grammar state machine; holds the verdict and drives the result item.
// ----------------------------------------------------------------------------
`default_nettype none

module cts_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_valid,
  input  wire cts_pkg::tok_t head,
  output logic               pop,
  cts_out_if.source          out_chan
);

  cts_pkg::phase_t                phase_r, phase_nxt;
  logic                           dbl_r, dbl_nxt;
  cts_pkg::verdict_t              ver_r, ver_nxt;
  cts_pkg::err_t                  code_r, code_nxt;
  logic [cts_pkg::LINE_BITS-1:0]  line_r, line_nxt;
  logic                           out_valid_r, out_valid_nxt;

  cts_pkg::tok_class_t t;
  cts_pkg::err_t       rej_code;
  logic                rej, acc;

  assign pop = q_valid && (!out_valid_r || out_chan.ready);
  assign t   = head.cls;

  always_comb begin
    phase_nxt = phase_r;
    dbl_nxt   = dbl_r;
    ver_nxt   = ver_r;
    code_nxt  = code_r;
    line_nxt  = line_r;
    rej       = 1'b0;
    acc       = 1'b0;
    rej_code  = cts_pkg::E_NONE;

    if (head.first) begin
      phase_nxt = cts_pkg::PH_LINE;
      dbl_nxt   = 1'b0;
      ver_nxt   = cts_pkg::V_PENDING;
      code_nxt  = cts_pkg::E_NONE;
      line_nxt  = '0;
    end

    if (ver_nxt == cts_pkg::V_PENDING) begin
      unique case (phase_nxt)
        cts_pkg::PH_LINE: begin
          if (t == cts_pkg::TK_OPEN) begin
            phase_nxt = cts_pkg::PH_HDR_OPEN;
            dbl_nxt   = 1'b0;
          end else if (t == cts_pkg::TK_KEY) begin
            phase_nxt = cts_pkg::PH_KV_AFTER_KEY;
          end else if (t == cts_pkg::TK_NEWLINE) begin
            phase_nxt = cts_pkg::PH_LINE;
          end else if (t == cts_pkg::TK_COMMENT) begin
            phase_nxt = cts_pkg::PH_TRAIL_CMT;
          end else if (t == cts_pkg::TK_EOF) begin
            acc = 1'b1;
          end else begin
            rej      = 1'b1;
            rej_code = cts_pkg::E_START;
          end
        end
        cts_pkg::PH_HDR_OPEN: begin
          if (t == cts_pkg::TK_OPEN) begin
            dbl_nxt   = 1'b1;
            phase_nxt = cts_pkg::PH_HDR_KEY;
          end else if (t == cts_pkg::TK_KEY) begin
            phase_nxt = cts_pkg::PH_HDR_AFTER_KEY;
          end else if (t == cts_pkg::TK_CLOSE) begin
            phase_nxt = dbl_nxt ? cts_pkg::PH_HDR_CLOSE2 : cts_pkg::PH_TRAIL;
          end else begin
            rej      = 1'b1;
            rej_code = cts_pkg::E_HEADER;
          end
        end
        cts_pkg::PH_HDR_KEY, cts_pkg::PH_HDR_AFTER_KEY: begin
          if (t == cts_pkg::TK_KEY) begin
            phase_nxt = cts_pkg::PH_HDR_AFTER_KEY;
          end else if (t == cts_pkg::TK_DOT &&
                       phase_nxt == cts_pkg::PH_HDR_AFTER_KEY) begin
            phase_nxt = cts_pkg::PH_HDR_KEY;
          end else if (t == cts_pkg::TK_CLOSE) begin
            phase_nxt = dbl_nxt ? cts_pkg::PH_HDR_CLOSE2 : cts_pkg::PH_TRAIL;
          end else begin
            rej      = 1'b1;
            rej_code = cts_pkg::E_HEADER;
          end
        end
        cts_pkg::PH_HDR_CLOSE2: begin
          if (t == cts_pkg::TK_CLOSE) begin
            phase_nxt = cts_pkg::PH_TRAIL;
            dbl_nxt   = 1'b0;
          end else begin
            rej      = 1'b1;
            rej_code = cts_pkg::E_HEADER;
          end
        end
        cts_pkg::PH_KV_KEY, cts_pkg::PH_KV_AFTER_KEY: begin
          if (t == cts_pkg::TK_KEY) begin
            phase_nxt = cts_pkg::PH_KV_AFTER_KEY;
          end else if (t == cts_pkg::TK_DOT &&
                       phase_nxt == cts_pkg::PH_KV_AFTER_KEY) begin
            phase_nxt = cts_pkg::PH_KV_KEY;
          end else if (t == cts_pkg::TK_ASSIGN) begin
            phase_nxt = cts_pkg::PH_KV_VALUE;
          end else begin
            rej      = 1'b1;
            rej_code = cts_pkg::E_KEY;
          end
        end
        cts_pkg::PH_KV_VALUE: begin
          if (t == cts_pkg::TK_VALUE || t == cts_pkg::TK_QUOTE) begin
            phase_nxt = cts_pkg::PH_TRAIL;
          end else if (t == cts_pkg::TK_OPEN) begin
            phase_nxt = cts_pkg::PH_ARR_ITEM;
          end else begin
            rej      = 1'b1;
            rej_code = cts_pkg::E_VALUE;
          end
        end
        cts_pkg::PH_ARR_ITEM, cts_pkg::PH_ARR_AFTER: begin
          if (t == cts_pkg::TK_VALUE || t == cts_pkg::TK_QUOTE ||
              t == cts_pkg::TK_KEY) begin
            phase_nxt = cts_pkg::PH_ARR_AFTER;
          end else if (t == cts_pkg::TK_COMMA &&
                       phase_nxt == cts_pkg::PH_ARR_AFTER) begin
            phase_nxt = cts_pkg::PH_ARR_ITEM;
          end else if (t == cts_pkg::TK_CLOSE) begin
            phase_nxt = cts_pkg::PH_TRAIL;
          end else begin
            rej      = 1'b1;
            rej_code = cts_pkg::E_VALUE;
          end
        end
        cts_pkg::PH_TRAIL, cts_pkg::PH_TRAIL_CMT: begin
          if (t == cts_pkg::TK_COMMENT && phase_nxt == cts_pkg::PH_TRAIL) begin
            phase_nxt = cts_pkg::PH_TRAIL_CMT;
          end else if (t == cts_pkg::TK_NEWLINE) begin
            phase_nxt = cts_pkg::PH_LINE;
          end else if (t == cts_pkg::TK_EOF) begin
            acc = 1'b1;
          end else begin
            rej      = 1'b1;
            rej_code = cts_pkg::E_TRAIL;
          end
        end
        default: begin
          phase_nxt = cts_pkg::PH_LINE;
          rej       = 1'b1;
          rej_code  = cts_pkg::E_START;
        end
      endcase

      if (rej) begin
        ver_nxt  = cts_pkg::V_REJECT;
        code_nxt = rej_code;
        line_nxt = head.line;
      end else if (acc) begin
        ver_nxt  = cts_pkg::V_ACCEPT;
        code_nxt = cts_pkg::E_NONE;
        line_nxt = '0;
      end
    end

    out_valid_nxt = pop || (out_valid_r && !out_chan.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= cts_pkg::PH_LINE;
      dbl_r       <= 1'b0;
      ver_r       <= cts_pkg::V_PENDING;
      code_r      <= cts_pkg::E_NONE;
      line_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        phase_r <= phase_nxt;
        dbl_r   <= dbl_nxt;
        ver_r   <= ver_nxt;
        code_r  <= code_nxt;
        line_r  <= line_nxt;
      end
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.verdict    = ver_r;
  assign out_chan.error_code = code_r;
  assign out_chan.error_line = line_r;

  a_clean_unless_rejected: assert property (@(posedge clk) disable iff (!rst_n)
    (ver_r != cts_pkg::V_REJECT) |-> (code_r == cts_pkg::E_NONE && line_r == '0))
    else $error("verdict without rejection carries an error");

  a_reject_has_code: assert property (@(posedge clk) disable iff (!rst_n)
    (ver_r == cts_pkg::V_REJECT) |-> (code_r != cts_pkg::E_NONE))
    else $error("rejection without error code");

  a_verdict_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !head.first && ver_r != cts_pkg::V_PENDING)
      |=> ($stable(ver_r) && $stable(code_r) && $stable(line_r)))
    else $error("held verdict changed without a new document");

  a_no_pop_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_chan.ready) |-> !pop)
    else $error("token consumed while result is stalled");

endmodule

`default_nettype wire
